FILE: sv/pfa_pkg.sv
// Package: word types, codes and helpers shared by the allocator modules.
`default_nettype none
package pfa_pkg;

    localparam int MAX_WORKERS = 8;
    localparam int LANE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int WAIT_W      = 32;

    // item kinds
    localparam logic KIND_REQ = 1'b0;
    localparam logic KIND_REL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd2;

    localparam logic [3:0]        ACTIVE_RESET = 4'd8;
    localparam logic [WAIT_W-1:0] WAIT_MAX     = '1;

    typedef struct packed {
        logic        kind;
        logic [15:0] tag;
        logic [7:0]  amount;
        logic [2:0]  target_worker;
    } t_in_word;

    typedef struct packed {
        logic              result_kind;
        logic [15:0]       echo_tag;
        logic              granted;
        logic [2:0]        chosen_worker;
        logic [7:0]        free_left;
        logic              release_error;
        logic [WAIT_W-1:0] wait_count;
    } t_out_word;

    // selection outcome handed from the fit search to the top level
    typedef struct packed {
        logic       found;
        logic [2:0] idx;
        logic [7:0] free_units;
    } t_sel;

    function automatic logic [7:0] lane8(input logic [63:0] word, input logic [2:0] i);
        lane8 = word[i*LANE_W +: LANE_W];
    endfunction

    // free units; used above capacity reads as none free
    function automatic logic [7:0] free_of(input logic [7:0] cap, input logic [7:0] used);
        free_of = (used >= cap) ? 8'd0 : 8'(cap - used);
    endfunction

endpackage
`default_nettype wire

FILE: sv/pfa_select.sv
// Fit search: lowest-priority-value active worker whose free units cover the amount.
`default_nettype none
module pfa_select
    import pfa_pkg::*;
#(
    parameter int NUM_WORKERS = MAX_WORKERS
) (
    input  wire logic [63:0]                        i_caps,
    input  wire logic [63:0]                        i_prios,
    input  wire logic [3:0]                         i_active,
    input  wire logic [NUM_WORKERS-1:0][LANE_W-1:0] i_used,
    input  wire logic [7:0]                         i_amount,
    output t_sel                                    o_sel
);

    logic [3:0] act_eff;
    logic [7:0] best_pri;

    assign act_eff = (32'(i_active) > NUM_WORKERS) ? 4'(NUM_WORKERS) : i_active;

    // linear scan; strict compare keeps the lower index on priority ties
    always_comb begin
        logic [7:0] fr;
        logic [7:0] pri;
        o_sel    = '0;
        best_pri = '0;
        for (int i = 0; i < NUM_WORKERS; i++) begin
            fr  = free_of(lane8(i_caps, 3'(i)), i_used[i]);
            pri = lane8(i_prios, 3'(i));
            if ((4'(i) < act_eff) && (i_amount <= fr) &&
                (!o_sel.found || (pri < best_pri))) begin
                o_sel.found      = 1'b1;
                o_sel.idx        = 3'(i);
                o_sel.free_units = fr;
                best_pri         = pri;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/priority_first_fit_allocator.sv
// Top level: priority-ordered first-fit allocator, used-unit counters and result register.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  command  | start, busy, i_cmd (t_in_word)          | taken when start & !busy
//  result   | o_done, o_result (t_out_word)           | one-cycle strobe, no backpressure
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata        | written when i_cfg_we is high
//
// One word per cycle while busy is low: the command is registered, the fit search over
// all worker lanes and the counter update run in the same cycle from that register, and
// the result register follows. The per-worker used counters are written in that same
// cycle, so back-to-back words see each other's effect. Synchronous active-low reset
// clears counters, valid flags, capacities and priorities and sets active to 8; busy
// is set by reset and clears once reset is released. The receiver cannot stall; results are never held.
`default_nettype none
module priority_first_fit_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_WORKERS = MAX_WORKERS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in_word              i_cmd,
    output logic                       o_done,
    output t_out_word                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration registers
    logic [63:0] r_caps;
    logic [63:0] r_prios;
    logic [3:0]  r_active;

    // command register
    t_in_word r_in;
    logic     r_in_vld;
    logic     r_busy;

    // state
    logic [NUM_WORKERS-1:0][LANE_W-1:0] r_used, n_used;
    logic [WAIT_W-1:0]                  r_defer, n_defer;

    // result register
    t_out_word r_out, n_out;
    logic      r_out_vld;

    t_sel       sel;
    logic       accept;
    logic       tgt_ok;
    logic [7:0] tgt_used;
    logic [7:0] tgt_new;

    assign accept = start & ~r_busy;
    assign busy   = r_busy;
    assign o_done   = r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps   <= '0;
            r_prios  <= '0;
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITIES: r_caps   <= i_cfg_wdata;
                CFG_PRIORITIES: r_prios  <= i_cfg_wdata;
                CFG_ACTIVE:     r_active <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= accept;
        end
        if (accept) begin
            r_in <= i_cmd;
        end
    end

    pfa_select #(
        .NUM_WORKERS(NUM_WORKERS)
    ) u_select (
        .i_caps  (r_caps),
        .i_prios (r_prios),
        .i_active(r_active),
        .i_used  (r_used),
        .i_amount(r_in.amount),
        .o_sel   (sel)
    );

    // release target lookup
    assign tgt_ok = (32'(r_in.target_worker) < NUM_WORKERS);

    always_comb begin
        tgt_used = '0;
        for (int i = 0; i < NUM_WORKERS; i++) begin
            if (r_in.target_worker == 3'(i)) begin
                tgt_used = r_used[i];
            end
        end
    end

    // release saturates at zero used
    assign tgt_new = (r_in.amount > tgt_used) ? 8'd0 : 8'(tgt_used - r_in.amount);

    always_comb begin
        n_used  = r_used;
        n_defer = r_defer;
        n_out   = '0;
        n_out.result_kind = r_in.kind;
        n_out.echo_tag    = r_in.tag;
        if (r_in_vld) begin
            if (r_in.kind == KIND_REQ) begin
                if (sel.found) begin
                    for (int i = 0; i < NUM_WORKERS; i++) begin
                        if (sel.idx == 3'(i)) begin
                            n_used[i] = 8'(r_used[i] + r_in.amount);
                        end
                    end
                end else if (r_defer != WAIT_MAX) begin
                    n_defer = r_defer + 1'b1;
                end
            end else if (tgt_ok) begin
                for (int i = 0; i < NUM_WORKERS; i++) begin
                    if (r_in.target_worker == 3'(i)) begin
                        n_used[i] = tgt_new;
                    end
                end
            end
        end
        if (r_in.kind == KIND_REQ) begin
            n_out.granted       = sel.found;
            n_out.chosen_worker = sel.found ? sel.idx : 3'd0;
            n_out.free_left     = sel.found ? 8'(sel.free_units - r_in.amount) : 8'd0;
        end else begin
            n_out.chosen_worker = r_in.target_worker;
            n_out.release_error = ~tgt_ok | (r_in.amount > tgt_used);
            n_out.free_left     = tgt_ok ?
                free_of(lane8(r_caps, r_in.target_worker), tgt_new) : 8'd0;
        end
        n_out.wait_count = n_defer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_defer   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_defer   <= n_defer;
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    // every result answers a word accepted through the command and result registers
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    // wait counter never goes backwards
    a_defer_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_defer >= $past(r_defer)))
        else $error("wait counter decreased");

    // a deferred request steps the counter by one unless full
    a_defer_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.result_kind == KIND_REQ) && !o_result.granted &&
         ($past(r_defer) != WAIT_MAX))
        |-> (o_result.wait_count == $past(r_defer) + 1'b1))
        else $error("deferred request did not count");

    // deferred requests report no worker and no free units
    a_defer_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.result_kind == KIND_REQ) && !o_result.granted)
        |-> ((o_result.chosen_worker == 3'd0) && (o_result.free_left == 8'd0) &&
             !o_result.release_error))
        else $error("deferred result fields not cleared");

endmodule
`default_nettype wire
